// ===== rtl/stq_pkg.sv =====
// Package for the sorted timeout queue: sizes, result codes and word types.
`default_nettype none
package stq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int MAX_OUT     = 16;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int OUT_W       = $clog2(MAX_OUT + 1);

   localparam logic [1:0] KIND_ACCEPTED = 2'd0;
   localparam logic [1:0] KIND_REJECTED = 2'd1;
   localparam logic [1:0] KIND_EXPIRED  = 2'd2;

   localparam logic MODE_TICK = 1'b0;
   localparam logic MODE_ADD  = 1'b1;

   typedef struct packed {
      logic        mode;
      logic [31:0] duration_seconds;
      logic [7:0]  event_tag;
   } req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [7:0]  out_tag;
      logic [31:0] registered_at;
      logic [31:0] out_duration;
      logic [31:0] fired_at;
      logic        last_result;
   } rsp_type;

   typedef struct packed {
      logic [31:0] deadline;
      logic [31:0] start;
      logic [31:0] length;
      logic [7:0]  tag;
   } entry_type;

endpackage
`default_nettype wire

// ===== rtl/sorted_timeout_queue_unit.sv =====
// Sorted timeout queue: deadline-ordered timer table with tick and add commands.
// Add: a rejection word in the cycle after acceptance when full; else one compare-and-move
//   per cycle walks the table from its tail, then the accepted word follows.
// Tick: prescaler and seconds update at acceptance, then one expired word per cycle from
//   the head, up to MAX_OUT words; busy drops after the last word, or when nothing is due.
// Reset (synchronous): table empty, prescaler and seconds zero, ticks_per_second 1.
// Results are shown for one cycle on rsp_valid; the receiver cannot stall them.
`default_nettype none
module sorted_timeout_queue_unit (
   input  wire              clock,
   input  wire              reset,
   input  wire              start,
   output logic             busy,
   input  wire stq_pkg::req_type req_data,
   output logic             rsp_valid,
   output stq_pkg::rsp_type rsp_data,
   input  wire              csr_valid,
   output logic             csr_ready,
   input  wire  [31:0]      csr_data
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_INSERT = 2'd1;
   localparam logic [1:0] ST_EXPIRE = 2'd2;

   logic [1:0]                  state_ff, state_in;
   logic [31:0]                 tps_ff, tps_in;
   logic [31:0]                 prescale_ff, prescale_in;
   logic [31:0]                 seconds_ff, seconds_in;
   logic [stq_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [stq_pkg::CNT_W-1:0]   idx_ff, idx_in;
   logic [stq_pkg::OUT_W-1:0]   nout_ff, nout_in;
   stq_pkg::entry_type          new_ff, new_in;
   stq_pkg::entry_type          entry_ff [stq_pkg::QUEUE_DEPTH];
   stq_pkg::entry_type          entry_in [stq_pkg::QUEUE_DEPTH];
   logic                        rsp_valid_ff, rsp_valid_in;
   stq_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   logic                        accept;
   logic [31:0]                 rate_m1;
   logic [32:0]                 deadline_sum;
   logic [stq_pkg::CNT_W-1:0]   idx_prev;
   stq_pkg::entry_type          prev_entry;
   logic                        due_head;
   logic                        due_next;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign rate_m1      = (tps_ff == 32'd0) ? 32'd0 : tps_ff - 32'd1;
   assign deadline_sum = {1'b0, seconds_ff} + {1'b0, req_data.duration_seconds};
   assign idx_prev     = idx_ff - stq_pkg::CNT_W'(1);
   assign prev_entry   = entry_ff[idx_prev[stq_pkg::IDX_W-1:0]];

   assign due_head = (count_ff != '0) && (entry_ff[0].deadline <= seconds_ff)
                     && (nout_ff < stq_pkg::OUT_W'(stq_pkg::MAX_OUT));
   assign due_next = (count_ff > stq_pkg::CNT_W'(1)) && (entry_ff[1].deadline <= seconds_ff)
                     && (nout_ff < stq_pkg::OUT_W'(stq_pkg::MAX_OUT - 1));

   always_comb begin
      state_in     = state_ff;
      tps_in       = tps_ff;
      prescale_in  = prescale_ff;
      seconds_in   = seconds_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      nout_in      = nout_ff;
      new_in       = new_ff;
      entry_in     = entry_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;

      if (csr_valid && csr_ready) begin
         tps_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.mode == stq_pkg::MODE_ADD) begin
                  if (count_ff >= stq_pkg::CNT_W'(stq_pkg::QUEUE_DEPTH)) begin
                     rsp_valid_in              = 1'b1;
                     rsp_data_in.result_kind   = stq_pkg::KIND_REJECTED;
                     rsp_data_in.out_tag       = req_data.event_tag;
                     rsp_data_in.registered_at = seconds_ff;
                     rsp_data_in.out_duration  = req_data.duration_seconds;
                     rsp_data_in.fired_at      = 32'd0;
                     rsp_data_in.last_result   = 1'b1;
                  end else begin
                     // saturate the deadline on carry out
                     new_in.deadline = deadline_sum[32] ? 32'hFFFF_FFFF : deadline_sum[31:0];
                     new_in.start    = seconds_ff;
                     new_in.length   = req_data.duration_seconds;
                     new_in.tag      = req_data.event_tag;
                     idx_in          = count_ff;
                     state_in        = ST_INSERT;
                  end
               end else begin
                  if (prescale_ff >= rate_m1) begin
                     prescale_in = 32'd0;
                     if (seconds_ff != 32'hFFFF_FFFF) begin
                        seconds_in = seconds_ff + 32'd1;
                     end
                  end else begin
                     prescale_in = prescale_ff + 32'd1;
                  end
                  nout_in  = '0;
                  state_in = ST_EXPIRE;
               end
            end
         end
         ST_INSERT: begin
            // walk from the tail: move later deadlines up one slot, then drop in the new one
            if ((idx_ff != '0) && (prev_entry.deadline > new_ff.deadline)) begin
               entry_in[idx_ff[stq_pkg::IDX_W-1:0]] = prev_entry;
               idx_in = idx_prev;
            end else begin
               entry_in[idx_ff[stq_pkg::IDX_W-1:0]] = new_ff;
               count_in                  = count_ff + stq_pkg::CNT_W'(1);
               rsp_valid_in              = 1'b1;
               rsp_data_in.result_kind   = stq_pkg::KIND_ACCEPTED;
               rsp_data_in.out_tag       = new_ff.tag;
               rsp_data_in.registered_at = new_ff.start;
               rsp_data_in.out_duration  = new_ff.length;
               rsp_data_in.fired_at      = 32'd0;
               rsp_data_in.last_result   = 1'b1;
               state_in                  = ST_IDLE;
            end
         end
         ST_EXPIRE: begin
            if (due_head) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.result_kind   = stq_pkg::KIND_EXPIRED;
               rsp_data_in.out_tag       = entry_ff[0].tag;
               rsp_data_in.registered_at = entry_ff[0].start;
               rsp_data_in.out_duration  = entry_ff[0].length;
               rsp_data_in.fired_at      = seconds_ff;
               rsp_data_in.last_result   = !due_next;
               // advance the table by one toward the head
               for (int i = 0; i < stq_pkg::QUEUE_DEPTH - 1; i++) begin
                  entry_in[i] = entry_ff[i + 1];
               end
               count_in = count_ff - stq_pkg::CNT_W'(1);
               nout_in  = nout_ff + stq_pkg::OUT_W'(1);
               if (!due_next) begin
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tps_ff       <= 32'd1;
         prescale_ff  <= 32'd0;
         seconds_ff   <= 32'd0;
         count_ff     <= '0;
         idx_ff       <= '0;
         nout_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tps_ff       <= tps_in;
         prescale_ff  <= prescale_in;
         seconds_ff   <= seconds_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         nout_ff      <= nout_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      new_ff      <= new_in;
      entry_ff    <= entry_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= stq_pkg::CNT_W'(stq_pkg::QUEUE_DEPTH))
      else $error("entry count above table depth");

   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INSERT) |-> (count_ff < stq_pkg::CNT_W'(stq_pkg::QUEUE_DEPTH)))
      else $error("insert running on a full table");

   a_add_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.result_kind != stq_pkg::KIND_EXPIRED)) |-> rsp_data.last_result)
      else $error("add result not marked last");

   a_fire_time: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.result_kind == stq_pkg::KIND_EXPIRED))
      |-> (rsp_data.fired_at == seconds_ff))
      else $error("expiry reported with stale seconds count");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_valid))
      else $error("busy or result right after reset");

endmodule
`default_nettype wire

// ===== tb/tb_sorted_timeout_queue_unit.sv =====
// Self-checking testbench for the sorted timeout queue: predicts the timer table and checks words.
module tb_sorted_timeout_queue_unit;

   localparam int CYCLE_LIMIT = 400000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   stq_pkg::req_type req_data = '0;
   logic             rsp_valid;
   stq_pkg::rsp_type rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [31:0]      csr_data = '0;

   sorted_timeout_queue_unit dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // Timer table as the block should hold it
   stq_pkg::entry_type timer_table [stq_pkg::QUEUE_DEPTH];
   int                 timer_count = 0;
   logic [31:0]        prescale = '0;
   logic [31:0]        seconds = '0;
   logic [31:0]        rate_setting = 32'd1;

   stq_pkg::req_type   command_q [$];
   stq_pkg::rsp_type   expected_words [$];
   int                 idle_pct = 0;
   int                 err_count = 0;
   int                 cycle_count = 0;

   function automatic void predict_command(input stq_pkg::req_type cmd);
      stq_pkg::rsp_type word;
      logic [32:0]      sum;
      logic [31:0]      deadline;
      logic [31:0]      rate;
      int               pos;
      int               n;
      word = '0;
      if (cmd.mode == stq_pkg::MODE_ADD) begin
         word.out_tag = cmd.event_tag;
         word.registered_at = seconds;
         word.out_duration = cmd.duration_seconds;
         word.fired_at = '0;
         word.last_result = 1'b1;
         if (timer_count >= stq_pkg::QUEUE_DEPTH) begin
            word.result_kind = stq_pkg::KIND_REJECTED;
         end else begin
            sum = {1'b0, seconds} + {1'b0, cmd.duration_seconds};
            deadline = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            pos = 0;
            // equal deadlines keep arrival order
            while (pos < timer_count && timer_table[pos].deadline <= deadline)
               pos++;
            for (int i = timer_count; i > pos; i--)
               timer_table[i] = timer_table[i - 1];
            timer_table[pos].deadline = deadline;
            timer_table[pos].start = seconds;
            timer_table[pos].length = cmd.duration_seconds;
            timer_table[pos].tag = cmd.event_tag;
            timer_count++;
            word.result_kind = stq_pkg::KIND_ACCEPTED;
         end
         expected_words.push_back(word);
      end else begin
         rate = (rate_setting == '0) ? 32'd1 : rate_setting;
         if (prescale >= rate - 32'd1) begin
            prescale = '0;
            if (seconds != 32'hFFFF_FFFF)
               seconds = seconds + 32'd1;
         end else begin
            prescale = prescale + 32'd1;
         end
         n = 0;
         while (n < stq_pkg::MAX_OUT && timer_count > 0
                && timer_table[0].deadline <= seconds) begin
            word.result_kind = stq_pkg::KIND_EXPIRED;
            word.out_tag = timer_table[0].tag;
            word.registered_at = timer_table[0].start;
            word.out_duration = timer_table[0].length;
            word.fired_at = seconds;
            word.last_result = 1'b0;
            expected_words.push_back(word);
            for (int i = 1; i < timer_count; i++)
               timer_table[i - 1] = timer_table[i];
            timer_count--;
            n++;
         end
         if (n > 0)
            expected_words[expected_words.size() - 1].last_result = 1'b1;
      end
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         err_count++;
      end
   endfunction

   // Driver: hold the word while busy, otherwise advance or insert a gap
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (start)
            predict_command(req_data);
         if (command_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
            start <= 1'b1;
            req_data <= command_q.pop_front();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: every strobed word is taken at the edge that ends its cycle
   always @(posedge clock) begin
      stq_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_words.size() == 0) begin
            $error("unexpected result word: kind %0d tag %0h", rsp_data.result_kind,
                   rsp_data.out_tag);
            err_count++;
         end else begin
            want = expected_words.pop_front();
            check_field("result_kind", 32'(want.result_kind), 32'(rsp_data.result_kind));
            check_field("out_tag", 32'(want.out_tag), 32'(rsp_data.out_tag));
            check_field("registered_at", want.registered_at, rsp_data.registered_at);
            check_field("out_duration", want.out_duration, rsp_data.out_duration);
            check_field("fired_at", want.fired_at, rsp_data.fired_at);
            check_field("last_result", 32'(want.last_result), 32'(rsp_data.last_result));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_sorted_timeout_queue_unit NOT OK");
         $finish;
      end
   end

   function automatic void push_tick();
      stq_pkg::req_type cmd;
      cmd = '0;
      cmd.mode = stq_pkg::MODE_TICK;
      cmd.duration_seconds = $urandom();
      cmd.event_tag = 8'($urandom_range(255));
      command_q.push_back(cmd);
   endfunction

   function automatic void push_add(input logic [31:0] dur, input logic [7:0] tag);
      stq_pkg::req_type cmd;
      cmd.mode = stq_pkg::MODE_ADD;
      cmd.duration_seconds = dur;
      cmd.event_tag = tag;
      command_q.push_back(cmd);
   endfunction

   // Mostly short timeouts so entries expire; a few huge ones stay parked
   function automatic void push_random(input int count);
      int          pick;
      logic [31:0] dur;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 55) begin
            push_tick();
         end else begin
            pick = $urandom_range(99);
            if (pick < 70)
               dur = $urandom_range(6);
            else if (pick < 90)
               dur = $urandom_range(40);
            else if (pick < 96)
               dur = '0;
            else
               dur = $urandom();
            push_add(dur, 8'($urandom_range(255)));
         end
      end
   endfunction

   // Wait until every word is out and the block has gone quiet
   task automatic drain();
      while (command_q.size() != 0 || start || expected_words.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
      while (busy)
         @(posedge clock);
   endtask

   task automatic write_rate(input logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      rate_setting = value;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: ordering, quiet tick, full table, burst of expiries
      idle_pct = 0;
      push_add(32'd0, 8'h00);
      push_add(32'd2, 8'hFF);
      push_add(32'd2, 8'h5A);
      push_add(32'd1, 8'hA5);
      push_tick();
      push_tick();
      push_tick();
      for (int i = 0; i < stq_pkg::QUEUE_DEPTH; i++)
         push_add(i % 2, 8'(8'h10 + i));
      push_add(32'd7, 8'h33);
      push_tick();
      push_add(32'hFFFF_FFFF, 8'hC3);
      drain();

      // zero rate counts a second on every tick
      write_rate(32'd0);
      idle_pct = 72;
      push_random(50);
      drain();

      // leave the prescaler at 4, then lower the rate under it
      write_rate(32'd5);
      idle_pct = 0;
      repeat (4) push_tick();
      drain();
      write_rate(32'd2);
      idle_pct = 14;
      push_tick();
      push_random(30);
      drain();

      // seconds frozen
      write_rate(32'hFFFF_FFFF);
      idle_pct = 72;
      push_random(20);
      drain();

      write_rate(32'd3);
      idle_pct = 0;
      push_random(15);
      drain();
      idle_pct = 72;
      push_random(15);
      drain();

      repeat (20) @(posedge clock);
      if (err_count == 0)
         $display("tb_sorted_timeout_queue_unit OK");
      else
         $display("tb_sorted_timeout_queue_unit NOT OK");
      $finish;
   end

endmodule
